### rtl/arv_pkg.sv
// ----------------------------------------------------------------------------
// arv_pkg
// Shared types and codes for the article record validator.
// ----------------------------------------------------------------------------
package arv_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] KIND_STRING = 2'd0;
   localparam logic [1:0] KIND_SPAN   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NO_LANG     = 3'd1;
   localparam logic [2:0] ST_NO_LENGTH   = 3'd2;
   localparam logic [2:0] ST_TEXT_SHORT  = 3'd3;
   localparam logic [2:0] ST_BAD_UTF8    = 3'd4;
   localparam logic [2:0] ST_NO_SPAN_LEN = 3'd5;
   localparam logic [2:0] ST_SPAN_SHORT  = 3'd6;
   localparam logic [2:0] ST_SPAN_RANGE  = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] string_index;
      logic [15:0] text_bytes;
      logic [15:0] text_units;
      logic [23:0] language;
      logic [15:0] span_offset;
      logic [15:0] span_units;
      logic [15:0] first_datum;
      logic [15:0] second_datum;
      logic [7:0]  span_kind;
      logic [2:0]  status;
      logic        end_of_run;
   } rec_type;

   // Records produced by one byte, packed from slot 0.
   typedef struct packed {
      logic    valid0;
      logic    valid1;
      rec_type rec0;
      rec_type rec1;
   } rec_pair_type;

endpackage

### rtl/arv_front.sv
// ----------------------------------------------------------------------------
// arv_front
// Byte parser: tracks the article structure, validates UTF-8 text and
// produces up to two records for each accepted byte.
// ----------------------------------------------------------------------------
module arv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           data_byte,
   input  logic                 last,
   output arv_pkg::rec_pair_type recs
);
   import arv_pkg::*;

   typedef enum logic [2:0] {
      PH_LEN, PH_LANG, PH_TEXT, PH_SPLEN, PH_SPBODY, PH_SKIP
   } phase_type;

   localparam logic [2:0] BOUNDS_BAD = 3'd7;

   phase_type   phase_ff, phase_in;
   logic [2:0]  fbc_ff, fbc_in;
   logic        odd_ff, odd_in;
   logic [15:0] sc_ff, sc_in;
   logic [15:0] trem_ff, trem_in;
   logic [15:0] units_ff, units_in;
   logic [1:0]  pend_ff, pend_in;
   logic [2:0]  bnd_ff, bnd_in;
   logic [55:0] buf_ff, buf_in;
   logic [23:0] lang_ff, lang_in;
   logic        failed_ff, failed_in;

   always_comb begin
      logic [55:0] buf_take;
      logic [2:0]  fbc_take;
      logic [7:0]  lo, hi;
      logic        pv;
      rec_type     prec, srec;
      logic [2:0]  st;
      logic [16:0] span_end;

      phase_in  = phase_ff;
      fbc_in    = fbc_ff;
      odd_in    = odd_ff;
      sc_in     = sc_ff;
      trem_in   = trem_ff;
      units_in  = units_ff;
      pend_in   = pend_ff;
      bnd_in    = bnd_ff;
      buf_in    = buf_ff;
      lang_in   = lang_ff;
      failed_in = failed_ff;
      pv        = 1'b0;
      prec      = '0;
      srec      = '0;
      st        = ST_OK;
      lo        = 8'h80;
      hi        = 8'hBF;
      span_end  = '0;

      buf_take = buf_ff | ({48'd0, data_byte} << {fbc_ff, 3'b000});
      fbc_take = fbc_ff + 3'd1;

      if (!failed_ff) begin
         case (phase_ff)
            PH_LANG: begin
               buf_in = buf_take;
               fbc_in = fbc_take;
               if (fbc_take == 3'd3) begin
                  lang_in  = buf_take[23:0];
                  buf_in   = '0;
                  fbc_in   = '0;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               buf_in = buf_take;
               fbc_in = fbc_take;
               if (fbc_take == 3'd2) begin
                  trem_in  = buf_take[15:0];
                  units_in = '0;
                  pend_in  = '0;
                  bnd_in   = '0;
                  fbc_in   = '0;
                  if (buf_take[15:0] == 16'd0) begin
                     // Empty text completes the string at once.
                     pv                = 1'b1;
                     prec.kind         = KIND_STRING;
                     prec.string_index = sc_ff;
                     prec.language     = odd_ff ? lang_ff : 24'd0;
                     buf_in            = '0;
                     phase_in          = PH_SPLEN;
                  end else begin
                     buf_in   = {40'd0, buf_take[15:0]};
                     phase_in = PH_TEXT;
                  end
               end
            end
            PH_TEXT: begin
               if (bnd_ff != BOUNDS_BAD) begin
                  if (pend_ff == 2'd0) begin
                     if (data_byte == 8'h00) begin
                        bnd_in = BOUNDS_BAD;
                     end else if (data_byte < 8'h80) begin
                        units_in = units_ff + 16'd1;
                     end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
                        pend_in  = 2'd1;
                        bnd_in   = 3'd0;
                        units_in = units_ff + 16'd1;
                     end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
                        pend_in  = 2'd2;
                        bnd_in   = (data_byte == 8'hE0) ? 3'd1 :
                                   (data_byte == 8'hED) ? 3'd2 : 3'd0;
                        units_in = units_ff + 16'd1;
                     end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
                        pend_in  = 2'd3;
                        bnd_in   = (data_byte == 8'hF0) ? 3'd3 :
                                   (data_byte == 8'hF4) ? 3'd4 : 3'd0;
                        units_in = units_ff + 16'd2;
                     end else begin
                        bnd_in = BOUNDS_BAD;
                     end
                  end else begin
                     case (bnd_ff)
                        3'd1:    lo = 8'hA0;
                        3'd2:    hi = 8'h9F;
                        3'd3:    lo = 8'h90;
                        3'd4:    hi = 8'h8F;
                        default: ;
                     endcase
                     if (data_byte < lo || data_byte > hi) begin
                        bnd_in = BOUNDS_BAD;
                     end else begin
                        pend_in = pend_ff - 2'd1;
                        bnd_in  = 3'd0;
                     end
                  end
               end
               trem_in = trem_ff - 16'd1;
               if (trem_in == 16'd0) begin
                  if (bnd_in == BOUNDS_BAD || pend_in != 2'd0) begin
                     failed_in = 1'b1;
                     buf_in    = {53'd0, ST_BAD_UTF8};
                     fbc_in    = '0;
                     phase_in  = PH_SKIP;
                  end else begin
                     pv                = 1'b1;
                     prec.kind         = KIND_STRING;
                     prec.string_index = sc_ff;
                     prec.text_bytes   = buf_ff[15:0];
                     prec.text_units   = units_in;
                     prec.language     = odd_ff ? lang_ff : 24'd0;
                     buf_in            = '0;
                     fbc_in            = '0;
                     phase_in          = PH_SPLEN;
                  end
               end
            end
            PH_SPLEN: begin
               buf_in = buf_take;
               fbc_in = fbc_take;
               if (fbc_take == 3'd2) begin
                  buf_in = '0;
                  fbc_in = '0;
                  if (buf_take[15:0] == 16'd0) begin
                     if (sc_ff != 16'hFFFF) begin
                        sc_in = sc_ff + 16'd1;
                     end
                     odd_in   = ~odd_ff;
                     phase_in = odd_ff ? PH_LEN : PH_LANG;
                  end else begin
                     trem_in  = buf_take[15:0];
                     phase_in = PH_SPBODY;
                  end
               end
            end
            PH_SPBODY: begin
               buf_in = buf_take;
               fbc_in = fbc_take;
               if (fbc_take == 3'd7) begin
                  pv                = 1'b1;
                  prec.kind         = KIND_SPAN;
                  prec.string_index = sc_ff;
                  prec.span_offset  = buf_take[15:0];
                  prec.span_units   = trem_ff;
                  prec.first_datum  = buf_take[31:16];
                  prec.second_datum = buf_take[47:32];
                  prec.span_kind    = buf_take[55:48];
                  buf_in            = '0;
                  fbc_in            = '0;
                  span_end = {1'b0, buf_take[15:0]} + {1'b0, trem_ff};
                  if (span_end > {1'b0, units_ff}) begin
                     failed_in = 1'b1;
                     buf_in    = {53'd0, ST_SPAN_RANGE};
                     phase_in  = PH_SKIP;
                  end else begin
                     phase_in = PH_SPLEN;
                  end
               end
            end
            default: ;
         endcase
      end

      if (failed_in) begin
         st = buf_in[2:0];
      end else begin
         case (phase_in)
            PH_LANG:  st = (fbc_in == 3'd0) ? ST_OK : ST_NO_LANG;
            PH_LEN:   st = (fbc_in == 3'd0 && !odd_in) ? ST_OK : ST_NO_LENGTH;
            PH_TEXT:  st = ST_TEXT_SHORT;
            PH_SPLEN: st = ST_NO_SPAN_LEN;
            default:  st = ST_SPAN_SHORT;
         endcase
      end
      srec.kind         = KIND_STATUS;
      srec.string_index = sc_in;
      srec.status       = st;
      srec.end_of_run   = 1'b1;
      prec.end_of_run   = !last;

      recs = '0;
      if (pv) begin
         recs.valid0 = 1'b1;
         recs.rec0   = prec;
         recs.valid1 = last;
         recs.rec1   = srec;
      end else begin
         recs.valid0 = last;
         recs.rec0   = srec;
      end

      if (last) begin
         phase_in  = PH_LEN;
         fbc_in    = '0;
         odd_in    = 1'b0;
         sc_in     = '0;
         trem_in   = '0;
         units_in  = '0;
         pend_in   = '0;
         bnd_in    = '0;
         buf_in    = '0;
         lang_in   = '0;
         failed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEN;
         fbc_ff    <= '0;
         odd_ff    <= 1'b0;
         sc_ff     <= '0;
         trem_ff   <= '0;
         units_ff  <= '0;
         pend_ff   <= '0;
         bnd_ff    <= '0;
         buf_ff    <= '0;
         lang_ff   <= '0;
         failed_ff <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         fbc_ff    <= fbc_in;
         odd_ff    <= odd_in;
         sc_ff     <= sc_in;
         trem_ff   <= trem_in;
         units_ff  <= units_in;
         pend_ff   <= pend_in;
         bnd_ff    <= bnd_in;
         buf_ff    <= buf_in;
         lang_ff   <= lang_in;
         failed_ff <= failed_in;
      end
   end

`ifndef ASSERT_OFF
   a_fail_skip: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> phase_ff == PH_SKIP)
      else $error("failed flag set outside skip phase");
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      recs.valid1 |-> recs.valid0 && recs.rec1.kind == KIND_STATUS)
      else $error("second record is not a status behind a first record");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      take && last |=> phase_ff == PH_LEN && !failed_ff && sc_ff == 16'd0)
      else $error("article end did not clear parser state");
`endif

endmodule

### rtl/arv_queue.sv
// ----------------------------------------------------------------------------
// arv_queue
// Result queue: takes up to two records a cycle from the parser and hands
// them out one transaction at a time.
// ----------------------------------------------------------------------------
module arv_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr,
   input  arv_pkg::rec_pair_type recs,
   input  logic                  rd,
   output arv_pkg::rec_type      head,
   output logic                  empty,
   output logic                  full
);
   import arv_pkg::*;

   rec_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wp_ff, wp_in;
   logic [QUEUE_AW-1:0]   rp_ff, rp_in;
   logic [QUEUE_AW:0]     cnt_ff, cnt_in;
   logic [1:0]            n_wr;
   logic                  do_rd;

   assign empty = (cnt_ff == '0);
   // Room for two records is kept so that any byte can be accepted.
   assign full  = (cnt_ff > (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
   assign head  = mem_ff[rp_ff];
   assign do_rd = rd && !empty;

   always_comb begin
      n_wr = '0;
      if (wr) begin
         n_wr = {1'b0, recs.valid0} + {1'b0, recs.valid1};
      end
      wp_in  = wp_ff + QUEUE_AW'(n_wr);
      rp_in  = rp_ff + QUEUE_AW'(do_rd);
      cnt_in = cnt_ff + (QUEUE_AW+1)'(n_wr) - (QUEUE_AW+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (wr && recs.valid0) begin
         mem_ff[wp_ff] <= recs.rec0;
      end
      if (wr && recs.valid1) begin
         mem_ff[wp_ff + QUEUE_AW'(1)] <= recs.rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_two_writes: assert property (@(posedge clock) disable iff (reset)
      n_wr == 2'd2 && !do_rd |=> cnt_ff == $past(cnt_ff) + (QUEUE_AW+1)'(2))
      else $error("double write not counted");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      wp_ff == rp_ff + QUEUE_AW'(cnt_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/article_record_validator.sv
// A record caused by a byte enters the result queue when the byte is taken
// and is shown on rsp_ at the queue head; a byte causes at most two records.
// Throughput: one byte per cycle while results are popped; the four-entry
// result queue raises full once fewer than two entries are free.
// Reset: synchronous, active high; clears parser state and the queue.
// ----------------------------------------------------------------------------
// article_record_validator
// Parses article bytes into string, span and status records.
// ----------------------------------------------------------------------------
module article_record_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_string_index,
   output logic [15:0] rsp_text_bytes,
   output logic [15:0] rsp_text_units,
   output logic [23:0] rsp_language,
   output logic [15:0] rsp_span_offset,
   output logic [15:0] rsp_span_units,
   output logic [15:0] rsp_first_datum,
   output logic [15:0] rsp_second_datum,
   output logic [7:0]  rsp_span_kind,
   output logic [2:0]  rsp_status,
   output logic        rsp_end_of_run
);
   import arv_pkg::*;

   rec_pair_type recs;
   rec_type      head;
   logic         take;

   assign take = push && !full;

   arv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .last      (req_last),
      .recs      (recs)
   );

   arv_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (take),
      .recs  (recs),
      .rd    (pop),
      .head  (head),
      .empty (empty),
      .full  (full)
   );

   assign rsp_kind         = head.kind;
   assign rsp_string_index = head.string_index;
   assign rsp_text_bytes   = head.text_bytes;
   assign rsp_text_units   = head.text_units;
   assign rsp_language     = head.language;
   assign rsp_span_offset  = head.span_offset;
   assign rsp_span_units   = head.span_units;
   assign rsp_first_datum  = head.first_datum;
   assign rsp_second_datum = head.second_datum;
   assign rsp_span_kind    = head.span_kind;
   assign rsp_status       = head.status;
   assign rsp_end_of_run   = head.end_of_run;

endmodule
